@@ src/sifsm_pkg.sv @@
// ----------------------------------------------------------------------------
// sifsm_pkg: shared types and constants for the safety interlock fault fsm
// codes, state enum, configuration and payload structures
// ----------------------------------------------------------------------------
package sifsm_pkg;

  localparam int TimeW = 32;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_ARMED = 2'd1,
    ST_RUN   = 2'd2,
    ST_FAULT = 2'd3
  } mode_t;

  localparam logic [2:0] CODE_NONE   = 3'd0;
  localparam logic [2:0] CODE_USER   = 3'd1;
  localparam logic [2:0] CODE_FALL   = 3'd2;
  localparam logic [2:0] CODE_LINK   = 3'd3;
  localparam logic [2:0] CODE_SENSOR = 3'd4;

  localparam logic [1:0] EFF_NONE  = 2'd0;
  localparam logic [1:0] EFF_WARN  = 2'd1;
  localparam logic [1:0] EFF_PAUSE = 2'd2;
  localparam logic [1:0] EFF_STOP  = 2'd3;

  localparam logic [1:0] SS_NONE   = 2'd0;
  localparam logic [1:0] SS_OK     = 2'd1;
  localparam logic [1:0] SS_LOCKED = 2'd2;
  localparam logic [1:0] SS_NOTARM = 2'd3;

  localparam logic [3:0] OP_PRESENCE = 4'd0;
  localparam logic [3:0] OP_USER_OFF = 4'd1;
  localparam logic [3:0] OP_LINK_UP  = 4'd2;
  localparam logic [3:0] OP_LINK_DN  = 4'd3;
  localparam logic [3:0] OP_FALL     = 4'd4;
  localparam logic [3:0] OP_SENSOR   = 4'd5;
  localparam logic [3:0] OP_BASELINE = 4'd6;
  localparam logic [3:0] OP_START    = 4'd7;
  localparam logic [3:0] OP_STOP     = 4'd8;
  localparam logic [3:0] OP_TIME     = 4'd9;

  localparam logic [2:0] REG_SENSOR_INST = 3'd0;
  localparam logic [2:0] REG_COOLDOWN    = 3'd1;
  localparam logic [2:0] REG_CONFIRM     = 3'd2;
  localparam logic [2:0] REG_FALL_STOP   = 3'd3;
  localparam logic [2:0] REG_POLICY      = 3'd4;
  localparam logic [2:0] REG_NOTICE_INT  = 3'd5;

  typedef struct packed {
    logic [3:0]       operation;
    logic             flag;
    logic [TimeW-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0] ctrl_state;
    logic [2:0] visible_reason;
    logic [1:0] safety_effect;
    logic [1:0] start_status;
    logic       stop_event;
    logic [2:0] stop_code;
    logic [1:0] stop_effect;
    logic       stop_source;
    logic       fall_notice;
  } out_item_t;

  typedef struct packed {
    logic        sensor_installed;
    logic [15:0] cooldown_ms;
    logic [15:0] confirm_ms;
    logic        fall_stop_enable;
    logic [3:0]  policy_flags;
    logic [15:0] fall_notice_interval_ms;
  } cfg_t;

  typedef struct packed {
    mode_t            mode;
    logic [2:0]       blocking;
    logic [2:0]       pause;
    logic [2:0]       warning;
    logic [TimeW-1:0] fault_time;
    logic             win_open;
    logic [TimeW-1:0] clear_start;
    logic             presence;
    logic             baseline;
    logic             sensor_ok;
    logic             sensor_known;
    logic [TimeW-1:0] last_notice;
  } state_t;

endpackage

@@ src/sifsm_if.sv @@
// ----------------------------------------------------------------------------
// sifsm channel interfaces
// valid/ready stream channel and configuration write channel
// ----------------------------------------------------------------------------
interface sifsm_in_if;
  import sifsm_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sifsm_out_if;
  import sifsm_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sifsm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

@@ src/safety_interlock_fault_fsm_unit.sv @@
// ----------------------------------------------------------------------------
// safety_interlock_fault_fsm_unit: safety interlock fault controller
//
//   channel | dir | contents
//   in_     | in  | operation, flag, now_ms
//   out_    | out | state, reason, effect, start and stop report, fall notice
//   cfg_    | in  | register index and write data
//
// one transaction per cycle while the skid stage is empty; the result is registered
// state update and result come from one combinational step on the state register
// output register with skid stage: input is taken while a result waits
// synchronous active-low reset restores register defaults and idle state
// ----------------------------------------------------------------------------
module safety_interlock_fault_fsm_unit (
  input  logic          clk,
  input  logic          rst_n,
  sifsm_in_if.sink      in_ch,
  sifsm_out_if.source   out_ch,
  sifsm_cfg_if.sink     cfg_ch
);
  import sifsm_pkg::*;

  cfg_t      cfg_q;
  logic      notice_reset;
  state_t    st_r, st_nxt, st_step;
  out_item_t res;
  out_item_t main_r, skid_r;
  logic      main_v_r, skid_v_r;
  logic      acc, pop;

  sifsm_cfg_regs u_cfg (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_ch), .cfg_q(cfg_q), .notice_reset(notice_reset)
  );

  sifsm_step u_step (
    .cfg(cfg_q), .st(st_r), .item(in_ch.data), .st_nxt(st_step), .res(res)
  );

  assign in_ch.ready = !skid_v_r;
  assign acc = in_ch.valid && in_ch.ready;
  assign pop = main_v_r && out_ch.ready;
  assign out_ch.valid = main_v_r;
  assign out_ch.data = main_r;

  always_comb begin
    st_nxt = acc ? st_step : st_r;
    if (notice_reset) st_nxt.last_notice = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{mode: ST_IDLE, blocking: CODE_NONE, pause: CODE_NONE,
                warning: CODE_NONE, default: '0};
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (!main_v_r || pop) begin
        main_v_r <= skid_v_r || acc;
        skid_v_r <= 1'b0;
      end else if (acc) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!main_v_r || pop) main_r <= skid_v_r ? skid_r : res;
    if (acc && main_v_r && !pop) skid_r <= res;
  end

  a_ready_skid: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> main_v_r) else $error("skid holds data while output empty");
  a_fault_blk: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.blocking != CODE_NONE) |-> (st_r.mode == ST_FAULT))
    else $error("blocking fault latched outside fault stop");
  a_fault_has_code: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.mode == ST_FAULT) |-> (st_r.blocking != CODE_NONE))
    else $error("fault stop without blocking code");
endmodule

@@ src/sifsm_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// sifsm_cfg_regs: configuration register file
// decodes writes; flags a change of fall_stop_enable
// ----------------------------------------------------------------------------
module sifsm_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  sifsm_cfg_if.sink         cfg,
  output sifsm_pkg::cfg_t   cfg_q,
  output logic              notice_reset
);
  import sifsm_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  assign cfg.ready = 1'b1;
  assign cfg_q = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    notice_reset = 1'b0;
    if (cfg.valid) begin
      case (cfg.index)
        REG_SENSOR_INST: cfg_nxt.sensor_installed = cfg.wdata[0];
        REG_COOLDOWN:    cfg_nxt.cooldown_ms = cfg.wdata;
        REG_CONFIRM:     cfg_nxt.confirm_ms = cfg.wdata;
        REG_FALL_STOP: begin
          cfg_nxt.fall_stop_enable = cfg.wdata[0];
          notice_reset = (cfg.wdata[0] != cfg_r.fall_stop_enable);
        end
        REG_POLICY:      cfg_nxt.policy_flags = cfg.wdata[3:0];
        REG_NOTICE_INT:  cfg_nxt.fall_notice_interval_ms = cfg.wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{sensor_installed: 1'b1, cooldown_ms: 16'd3000,
                 confirm_ms: 16'd1000, fall_stop_enable: 1'b1,
                 policy_flags: 4'hf, fall_notice_interval_ms: 16'd5000};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end
endmodule

@@ src/sifsm_step.sv @@
// ----------------------------------------------------------------------------
// sifsm_step: combinational next-state and result logic for one event
// ----------------------------------------------------------------------------
module sifsm_step (
  input  sifsm_pkg::cfg_t   cfg,
  input  sifsm_pkg::state_t st,
  input  sifsm_pkg::in_item_t item,
  output sifsm_pkg::state_t st_nxt,
  output sifsm_pkg::out_item_t res
);
  import sifsm_pkg::*;

  function automatic logic can_arm(state_t s, cfg_t c);
    return (s.pause == CODE_NONE) &&
           (!c.sensor_installed || s.presence) && (!c.sensor_installed || s.baseline);
  endfunction

  function automatic state_t sync_ready(state_t s, cfg_t c);
    state_t r;
    r = s;
    if (s.blocking != CODE_NONE) r.mode = ST_FAULT;
    else if (s.mode == ST_RUN) r.mode = ST_RUN;
    else if (s.pause != CODE_NONE) r.mode = ST_IDLE;
    else r.mode = can_arm(s, c) ? ST_ARMED : ST_IDLE;
    return r;
  endfunction

  function automatic logic recovery_met(state_t s);
    logic m;
    case (s.blocking)
      CODE_USER:   m = s.presence && s.baseline;
      CODE_FALL:   m = !s.presence;
      CODE_SENSOR: m = s.sensor_known && s.sensor_ok;
      default:     m = 1'b1;
    endcase
    return m;
  endfunction

  function automatic state_t clear_blocking(state_t s, cfg_t c);
    state_t r;
    r = s;
    r.blocking = CODE_NONE;
    r.win_open = 1'b0;
    r.clear_start = '0;
    return sync_ready(r, c);
  endfunction

  function automatic state_t maybe_clear(state_t s, cfg_t c, logic [TimeW-1:0] now);
    state_t r;
    logic [TimeW-1:0] age, held;
    r = s;
    age = now - s.fault_time;
    held = now - s.clear_start;
    if (s.blocking != CODE_NONE && s.mode == ST_FAULT) begin
      if (age < TimeW'(c.cooldown_ms)) r.win_open = 1'b0;
      else if (!recovery_met(s)) r.win_open = 1'b0;
      else if (!s.win_open) begin
        r.win_open = 1'b1;
        r.clear_start = now;
      end else if (held >= TimeW'(c.confirm_ms)) r = clear_blocking(s, c);
    end
    return r;
  endfunction

  logic [TimeW-1:0] now, nage;
  logic stop_f, stop_s, notice;
  logic [2:0] stop_c;
  logic [1:0] stop_e, sstat;
  logic blk_req, pause_req, changed;
  logic [2:0] blk_code, pause_code;

  always_comb begin
    state_t t;
    now = item.now_ms;
    nage = now - st.last_notice;
    t = st;
    stop_f = 1'b0;
    stop_c = CODE_NONE;
    stop_e = EFF_NONE;
    stop_s = 1'b0;
    notice = 1'b0;
    sstat = SS_NONE;
    blk_req = 1'b0;
    pause_req = 1'b0;
    blk_code = CODE_NONE;
    pause_code = CODE_NONE;
    changed = !st.sensor_known || (st.sensor_ok != item.flag);
    case (item.operation)
      OP_PRESENCE, OP_BASELINE: begin
        if (item.operation == OP_PRESENCE) t.presence = item.flag;
        else t.baseline = item.flag;
        if (t.pause == CODE_USER && t.presence && t.baseline) begin
          t.pause = CODE_NONE;
          t = sync_ready(t, cfg);
        end else if (t.blocking != CODE_NONE) t = maybe_clear(t, cfg, now);
        else t = sync_ready(t, cfg);
      end
      OP_USER_OFF: begin
        t.presence = 1'b0;
        if (!(st.mode == ST_RUN && cfg.sensor_installed && st.baseline))
          t = sync_ready(t, cfg);
        else if (cfg.policy_flags[0]) begin
          pause_req = 1'b1; pause_code = CODE_USER;
        end else begin
          blk_req = 1'b1; blk_code = CODE_USER;
        end
      end
      OP_LINK_UP: begin
        if (t.warning == CODE_LINK) t.warning = CODE_NONE;
        if (t.sensor_known && !t.sensor_ok) t.warning = CODE_SENSOR;
      end
      OP_LINK_DN: begin
        if (cfg.policy_flags[1]) begin
          blk_req = 1'b1; blk_code = CODE_LINK;
        end else t.warning = CODE_LINK;
      end
      OP_FALL: begin
        if (!cfg.fall_stop_enable) begin
          if (st.last_notice == '0 || nage >= TimeW'(cfg.fall_notice_interval_ms)) begin
            t.last_notice = now;
            notice = 1'b1;
          end
        end else begin
          t.last_notice = '0;
          if (cfg.policy_flags[2]) begin
            blk_req = 1'b1; blk_code = CODE_FALL;
          end else begin
            pause_req = 1'b1; pause_code = CODE_FALL;
          end
        end
      end
      OP_SENSOR: begin
        if (!cfg.sensor_installed) begin
          t.sensor_known = 1'b0;
          t.sensor_ok = 1'b0;
          if (t.blocking == CODE_SENSOR) t = clear_blocking(t, cfg);
          else begin
            if (t.warning == CODE_SENSOR) t.warning = CODE_NONE;
            t = sync_ready(t, cfg);
          end
        end else begin
          t.sensor_known = 1'b1;
          t.sensor_ok = item.flag;
          if (!item.flag && changed) begin
            if (cfg.policy_flags[3] && st.mode == ST_RUN) begin
              blk_req = 1'b1; blk_code = CODE_SENSOR;
            end else t.warning = CODE_SENSOR;
          end else begin
            if (item.flag && t.warning == CODE_SENSOR) t.warning = CODE_NONE;
            if (t.blocking != CODE_NONE) t = maybe_clear(t, cfg, now);
            else t = sync_ready(t, cfg);
          end
        end
      end
      OP_START: begin
        if (t.blocking != CODE_NONE) t = maybe_clear(t, cfg, now);
        if (t.blocking != CODE_NONE) sstat = SS_LOCKED;
        else if (t.pause != CODE_NONE) sstat = SS_NOTARM;
        else if (cfg.sensor_installed && !(t.presence && t.baseline)) sstat = SS_NOTARM;
        else begin
          t.mode = ST_RUN; sstat = SS_OK;
        end
      end
      OP_STOP: begin
        if (t.blocking != CODE_NONE) t.mode = ST_FAULT;
        else begin
          if (t.mode == ST_RUN) begin
            stop_f = 1'b1;
            stop_c = t.pause;
            stop_e = (t.pause != CODE_NONE) ? EFF_PAUSE : EFF_NONE;
            stop_s = (t.pause != CODE_NONE);
          end
          t.mode = can_arm(t, cfg) ? ST_ARMED : ST_IDLE;
        end
      end
      OP_TIME: t = maybe_clear(t, cfg, now);
      default: ;
    endcase
    if (blk_req) begin
      if (t.mode == ST_RUN) begin
        stop_f = 1'b1; stop_c = blk_code; stop_e = EFF_STOP; stop_s = 1'b1;
      end
      t.blocking = blk_code;
      t.fault_time = now;
      t.win_open = 1'b0;
      t.clear_start = '0;
      t.pause = CODE_NONE;
      t.mode = ST_FAULT;
    end
    if (pause_req && t.pause != pause_code) begin
      t.pause = pause_code;
      t.win_open = 1'b0;
      t.clear_start = '0;
      if (t.mode == ST_RUN && t.blocking == CODE_NONE) begin
        stop_f = 1'b1; stop_c = pause_code; stop_e = EFF_PAUSE; stop_s = 1'b1;
        t.mode = can_arm(t, cfg) ? ST_ARMED : ST_IDLE;
      end
      t = sync_ready(t, cfg);
    end
    st_nxt = t;
    res.ctrl_state = t.mode;
    if (t.blocking != CODE_NONE) begin
      res.visible_reason = t.blocking; res.safety_effect = EFF_STOP;
    end else if (t.pause != CODE_NONE) begin
      res.visible_reason = t.pause; res.safety_effect = EFF_PAUSE;
    end else if (t.warning != CODE_NONE) begin
      res.visible_reason = t.warning; res.safety_effect = EFF_WARN;
    end else begin
      res.visible_reason = CODE_NONE; res.safety_effect = EFF_NONE;
    end
    res.start_status = sstat;
    res.stop_event = stop_f;
    res.stop_code = stop_c;
    res.stop_effect = stop_e;
    res.stop_source = stop_s;
    res.fall_notice = notice;
  end
endmodule
